// ===== hw/rtl/sitoa_pkg.sv =====
package sitoa_pkg;

	// Field widths fixed by the item format
	localparam int VALUE_W        = 64;
	localparam int CHAR_W         = 8;
	localparam int VALUE_BITS_DEF = 64;

	// Command codes
	localparam logic CMD_DEC = 1'b0;
	localparam logic CMD_HEX = 1'b1;

	// ASCII codes
	localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_X       = 8'h78;
	localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;

	// Input item
	typedef struct packed {
		logic                      command;
		logic signed [VALUE_W-1:0] value;
	} in_item_t;

	// Result item
	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last;
	} out_item_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HEX0,
		ST_HEXX,
		ST_CONV,
		ST_SIGN,
		ST_SKIP,
		ST_DIGIT
	} state_t;

	// Map one digit (0 to 15) onto its upper-case ASCII code
	function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
		logic [CHAR_W-1:0] ch;
		if (d < 4'd10) begin
			ch = CHAR_ZERO + CHAR_W'(d);
		end else begin
			ch = CHAR_UPPER_A + CHAR_W'(d - 4'd10);
		end
		return ch;
	endfunction

endpackage

// ===== hw/rtl/signed_int_to_ascii_radix.sv =====
// Signed integer to ASCII text, decimal or hexadecimal.
// Input: pulse start with item (command, value) while busy is low; the item is
// taken at that edge. Only the low VALUE_BITS bits of value are used, the top
// one of them being the sign. command = CMD_HEX prints "0x" first.
// Output: one character per strobe cycle, most significant digit first, no
// leading zeros, '-' ahead of the digits of a negative number (after "0x" in
// hex). The final character of a number has last set. The receiver cannot
// stall: every strobe cycle is one delivered character.
// The digit register holds max(decimal digits, hex digits) BCD or hex digits
// (20 at VALUE_BITS = 64). Decimal conversion runs the bit-serial
// shift-and-add-3 binary to BCD loop, one magnitude bit a cycle; hex loads
// the magnitude into the digit register directly.
// The digit register is then shifted out one digit a cycle: leading zeros are
// dropped without a strobe, the rest are printed. The first character is
// formed from the sequencer state and leaves through the output register in
// the next cycle.
// Reset clears the sequencer and the strobe; no item is in flight after it.
module signed_int_to_ascii_radix #(
	parameter int VALUE_BITS = sitoa_pkg::VALUE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  sitoa_pkg::in_item_t  item,
	output logic                 strobe,
	output sitoa_pkg::out_item_t result
);

	localparam int DEC_DIGITS = (VALUE_BITS * 3) / 10 + 1;
	localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
	localparam int NDIG       = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
	localparam int DW         = 4 * NDIG;
	localparam int CNT_W      = $clog2(NDIG + 1);
	localparam int BIT_W      = $clog2(VALUE_BITS + 1);

	sitoa_pkg::state_t state_q, state_d;

	logic                  hex_q;
	logic                  neg_q;
	logic [VALUE_BITS-1:0] mag_q;
	logic [DW-1:0]         dig_q;
	logic [DW-1:0]         dig_adj;
	logic [BIT_W-1:0]      bits_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [3:0]            top_digit;

	logic [VALUE_BITS-1:0] in_v;
	logic                  in_neg;
	logic [VALUE_BITS-1:0] in_mag;
	logic                  accept;

	logic                  strobe_d;
	sitoa_pkg::out_item_t  result_d;
	logic                  strobe_q;
	sitoa_pkg::out_item_t  result_q;

	// Take the item apart and form its magnitude
	assign accept = start && (state_q == sitoa_pkg::ST_IDLE);
	assign in_v   = item.value[VALUE_BITS-1:0];
	assign in_neg = in_v[VALUE_BITS-1];
	assign in_mag = in_neg ? (~in_v + VALUE_BITS'(1)) : in_v;

	assign top_digit = dig_q[DW-1 -: 4];

	// Add 3 to every BCD digit of 5 or more before the next shift
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (dig_q[4*i +: 4] >= 4'd5) begin
				dig_adj[4*i +: 4] = dig_q[4*i +: 4] + 4'd3;
			end else begin
				dig_adj[4*i +: 4] = dig_q[4*i +: 4];
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sitoa_pkg::ST_IDLE: begin
				if (start) begin
					state_d = (item.command == sitoa_pkg::CMD_HEX) ? sitoa_pkg::ST_HEX0
						: sitoa_pkg::ST_CONV;
				end
			end
			sitoa_pkg::ST_HEX0: begin
				state_d = sitoa_pkg::ST_HEXX;
			end
			sitoa_pkg::ST_HEXX: begin
				state_d = neg_q ? sitoa_pkg::ST_SIGN : sitoa_pkg::ST_SKIP;
			end
			sitoa_pkg::ST_CONV: begin
				if (bits_q == BIT_W'(1)) begin
					state_d = neg_q ? sitoa_pkg::ST_SIGN : sitoa_pkg::ST_SKIP;
				end
			end
			sitoa_pkg::ST_SIGN: begin
				state_d = sitoa_pkg::ST_SKIP;
			end
			sitoa_pkg::ST_SKIP: begin
				if (top_digit != 4'd0 || cnt_q == CNT_W'(1)) begin
					state_d = sitoa_pkg::ST_DIGIT;
				end
			end
			sitoa_pkg::ST_DIGIT: begin
				if (cnt_q == CNT_W'(1)) begin
					state_d = sitoa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sitoa_pkg::ST_IDLE;
			end
		endcase
	end

	// Character for the current state
	always_comb begin
		strobe_d           = 1'b0;
		result_d.character = sitoa_pkg::CHAR_ZERO;
		result_d.last      = 1'b0;
		case (state_q)
			sitoa_pkg::ST_HEX0: begin
				strobe_d = 1'b1;
			end
			sitoa_pkg::ST_HEXX: begin
				strobe_d           = 1'b1;
				result_d.character = sitoa_pkg::CHAR_X;
			end
			sitoa_pkg::ST_SIGN: begin
				strobe_d           = 1'b1;
				result_d.character = sitoa_pkg::CHAR_MINUS;
			end
			sitoa_pkg::ST_DIGIT: begin
				strobe_d           = 1'b1;
				result_d.character = sitoa_pkg::digit_char(top_digit);
				result_d.last      = (cnt_q == CNT_W'(1));
			end
			default: begin
				strobe_d = 1'b0;
			end
		endcase
	end

	// Sequencer and output strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sitoa_pkg::ST_IDLE;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= strobe_d;
		end
	end

	// Datapath: load, convert, shift digits out
	always_ff @(posedge clk) begin
		result_q <= result_d;
		if (accept) begin
			hex_q  <= (item.command == sitoa_pkg::CMD_HEX);
			neg_q  <= in_neg;
			mag_q  <= in_mag;
			bits_q <= BIT_W'(VALUE_BITS);
			cnt_q  <= CNT_W'(NDIG);
			if (item.command == sitoa_pkg::CMD_HEX) begin
				dig_q <= DW'(in_mag);
			end else begin
				dig_q <= '0;
			end
		end else begin
			case (state_q)
				sitoa_pkg::ST_CONV: begin
					dig_q  <= {dig_adj[DW-2:0], mag_q[VALUE_BITS-1]};
					mag_q  <= mag_q << 1;
					bits_q <= bits_q - BIT_W'(1);
				end
				sitoa_pkg::ST_SKIP: begin
					if (top_digit == 4'd0 && cnt_q != CNT_W'(1)) begin
						dig_q <= dig_q << 4;
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				sitoa_pkg::ST_DIGIT: begin
					dig_q <= dig_q << 4;
					cnt_q <= cnt_q - CNT_W'(1);
				end
				default: begin
					dig_q <= dig_q;
				end
			endcase
		end
	end

	assign busy   = (state_q != sitoa_pkg::ST_IDLE);
	assign strobe = strobe_q;
	assign result = result_q;

	// The final character leaves only once the sequencer is back at rest
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && result_q.last |-> state_q == sitoa_pkg::ST_IDLE)
		else $error("last character while still busy");

	// Digit count never runs out while digits remain to be printed
	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sitoa_pkg::ST_DIGIT || state_q == sitoa_pkg::ST_SKIP |-> cnt_q != '0)
		else $error("digit counter empty during output");

	// Conversion always has bits left to shift
	a_bits_live: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sitoa_pkg::ST_CONV |-> bits_q != '0)
		else $error("conversion ran past the last bit");

	// Decimal digits stay valid BCD
	a_bcd_digit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sitoa_pkg::ST_DIGIT && !hex_q |-> top_digit <= 4'd9)
		else $error("BCD digit out of range");

	// A strobe follows every cycle spent printing a digit
	a_digit_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sitoa_pkg::ST_DIGIT |=> strobe_q)
		else $error("digit cycle without strobe");

endmodule
